// ===== rtl/core/lse_pkg.sv =====
// Shared constants and types for the LSB steganography extractor.
package lse_pkg;

  // Cover byte positions are counted from one and saturate at the top of this width.
  localparam int unsigned PosW = 34;
  localparam int unsigned HdrW = 32;
  localparam int unsigned SentW = 29;
  localparam int unsigned KeyW = 64;
  localparam int unsigned KeyLenW = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DefaultMaxKeyChars = 8;

  // Header layout in cover byte positions.
  localparam logic [PosW-1:0] OffsetFirst = PosW'(200);
  localparam logic [PosW-1:0] LengthFirst = PosW'(232);
  localparam logic [PosW-1:0] HeaderEnd = PosW'(264);
  localparam logic [PosW-1:0] HeaderLast = PosW'(263);
  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgKeyBytes = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgKeyLength = CfgIdxW'(1);

  // Status that the framing unit reports for the item now in the input register.
  typedef struct packed {
    logic take;
    logic [SentW-1:0] whole_bytes;
  } lse_frame_t;

endpackage

// ===== rtl/core/lse_frame.sv =====
// Header parsing and payload window tracking over the cover byte stream.
module lse_frame (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              bit_i,
  output lse_pkg::lse_frame_t frame_o
);
  import lse_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [HdrW-1:0] off_q, off_d;
  logic [HdrW-1:0] len_q, len_d;
  logic            hdr_q, hdr_d;
  logic [HdrW:0]   win_end;
  logic            in_off, in_len;

  // Shift header bits in while the position lies inside each header field.
  assign in_off = (pos_q >= OffsetFirst) && (pos_q < LengthFirst);
  assign in_len = (pos_q >= LengthFirst) && (pos_q < HeaderEnd);
  assign off_d = in_off ? {off_q[HdrW-2:0], bit_i} : off_q;
  assign len_d = in_len ? {len_q[HdrW-2:0], bit_i} : len_q;
  assign hdr_d = hdr_q | (pos_q == HeaderLast);

  // The bit is payload when offset < position <= offset + length.
  assign win_end = {1'b0, off_d} + {1'b0, len_d};
  assign frame_o.take = hdr_d && (pos_q > PosW'(off_d)) && (pos_q <= PosW'(win_end));
  assign frame_o.whole_bytes = len_d[HdrW-1:3];

  // Position counter saturates so that no bit is taken after overflow.
  assign pos_d = (pos_q == PosMax) ? pos_q : pos_q + PosW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosW'(1);
      off_q <= '0;
      len_q <= '0;
      hdr_q <= 1'b0;
    end else if (step_i) begin
      pos_q <= pos_d;
      off_q <= off_d;
      len_q <= len_d;
      hdr_q <= hdr_d;
    end
  end

endmodule

// ===== rtl/core/lsb_stego_extractor.sv =====
// Top level of the LSB steganography payload extractor.
//
//   Channel   Signals                                        Direction  Moves
//   cover     cover_valid_i/ready_o, cover_byte_i            in         one cover byte
//   text      text_valid_o/ready_i, text_byte_o, last_byte_o out        one payload byte
//   cfg       cfg_valid_i/ready_o, cfg_index_i, cfg_data_i   in         one register write
//
// One cover byte is taken every cycle while results are drained; a payload bit
// goes through the input register and then the result register to its text byte.
// Every eighth payload bit gives one text byte. A held result keeps the
// input register from moving on, so the cover input stalls once that register is
// full. Reset returns the position and the key length to one and clears the
// header, the bit gatherer, the key index and the key characters.
module lsb_stego_extractor #(
  parameter int unsigned MAX_KEY_CHARS = lse_pkg::DefaultMaxKeyChars
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cover_valid_i,
  output logic                        cover_ready_o,
  input  logic [7:0]                  cover_byte_i,
  output logic                        text_valid_o,
  input  logic                        text_ready_i,
  output logic [7:0]                  text_byte_o,
  output logic                        last_byte_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lse_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lse_pkg::KeyW-1:0]    cfg_data_i
);
  import lse_pkg::*;

  localparam int unsigned KeyIdxW = (MAX_KEY_CHARS > 1) ? $clog2(MAX_KEY_CHARS) : 1;
  localparam logic [KeyLenW-1:0] KeyMax = KeyLenW'(MAX_KEY_CHARS);

  logic [KeyW-1:0]    key_q;
  logic [KeyLenW-1:0] klen_q;
  logic               in_valid_q, in_bit_q;
  logic               out_valid_q, out_last_q;
  logic [7:0]         out_byte_q;
  logic [7:0]         gath_q, gath_d;
  logic [2:0]         held_q, held_d;
  logic [KeyIdxW-1:0] kidx_q, kidx_d, kidx_use;
  logic [SentW-1:0]   sent_q, sent_d;
  logic [KeyLenW-1:0] klen_eff, kidx_inc;
  logic [7:0]         key_char;
  logic               advance, produce;
  lse_frame_t         frame;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      klen_q <= KeyLenW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgKeyBytes: key_q <= cfg_data_i;
        CfgKeyLength: klen_q <= cfg_data_i[KeyLenW-1:0];
        default: ;
      endcase
    end
  end

  // The item in the input register moves on when the result register can take it.
  assign advance = in_valid_q && (!out_valid_q || text_ready_i);
  assign cover_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (cover_ready_o) begin
      in_valid_q <= cover_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cover_valid_i && cover_ready_o) begin
      in_bit_q <= cover_byte_i[0];
    end
  end

  lse_frame u_frame (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .bit_i  (in_bit_q),
    .frame_o(frame)
  );

  // Payload bits pack MSB first; the eighth bit completes a byte.
  assign produce = frame.take && (held_q == 3'd7);
  assign gath_d = produce ? 8'd0 : {gath_q[6:0], in_bit_q};
  assign held_d = held_q + 3'd1;

  // Clamp the key length and restart the index when it has run past it.
  always_comb begin
    klen_eff = klen_q;
    if (klen_q == '0) begin
      klen_eff = KeyLenW'(1);
    end else if (klen_q > KeyMax) begin
      klen_eff = KeyMax;
    end
  end

  assign kidx_use = (KeyLenW'(kidx_q) >= klen_eff) ? '0 : kidx_q;
  assign key_char = key_q[{kidx_use, 3'b000} +: 8];
  assign kidx_inc = KeyLenW'(kidx_use) + KeyLenW'(1);
  assign kidx_d = (kidx_inc >= klen_eff) ? '0 : kidx_inc[KeyIdxW-1:0];
  assign sent_d = sent_q + SentW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gath_q <= '0;
      held_q <= '0;
      kidx_q <= '0;
      sent_q <= '0;
    end else if (advance && frame.take) begin
      gath_q <= gath_d;
      held_q <= held_d;
      if (produce) begin
        kidx_q <= kidx_d;
        sent_q <= sent_d;
      end
    end
  end

  // Result register holds a finished byte until its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && produce) begin
      out_valid_q <= 1'b1;
    end else if (text_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && produce) begin
      out_byte_q <= {gath_q[6:0], in_bit_q} ^ key_char;
      out_last_q <= (sent_d == frame.whole_bytes);
    end
  end

  assign text_valid_o = out_valid_q;
  assign text_byte_o = out_byte_q;
  assign last_byte_o = out_last_q;

endmodule

// ===== tb/lsb_stego_extractor_checker.sv =====
// Checker that predicts and compares the text bytes of the LSB steganography extractor.
module lsb_stego_extractor_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cover_valid_i,
  input  logic                        cover_ready_i,
  input  logic [7:0]                  cover_byte_i,
  input  logic                        text_valid_i,
  input  logic                        text_ready_i,
  input  logic [7:0]                  text_byte_i,
  input  logic                        last_byte_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [lse_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lse_pkg::KeyW-1:0]    cfg_data_i,
  input  logic                        end_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o,
  output int unsigned                 checked_o
);
  import lse_pkg::*;

  localparam int unsigned MaxKeyChars = DefaultMaxKeyChars;
  localparam int unsigned MaxReports = 20;

  typedef struct packed {
    logic [7:0] text;
    logic       last;
  } text_result_t;

  // Text bytes predicted but not yet seen on the output, oldest first.
  text_result_t text_expect_q[$];

  // Own copy of the key registers.
  logic [KeyW-1:0]    key_q;
  logic [KeyLenW-1:0] key_len_q;

  // Own copy of the extraction state.
  logic [PosW-1:0]  pos_q;
  logic [HdrW-1:0]  offset_q;
  logic [HdrW-1:0]  length_q;
  logic             header_done_q;
  logic [7:0]       gather_q;
  logic [3:0]       bits_held_q;
  logic [2:0]       key_idx_q;
  logic [SentW-1:0] sent_q;

  int unsigned fails;
  int unsigned checked;
  bit          end_seen;

  // Advance the extraction by one cover byte and queue a text byte when eight
  // payload bits have been gathered.
  task automatic take_cover_lsb(input logic lsb);
    logic [HdrW:0] window_last;
    int unsigned   klen;
    int unsigned   kidx;
    text_result_t  res;
    if (pos_q >= OffsetFirst && pos_q < LengthFirst) begin
      offset_q = {offset_q[HdrW-2:0], lsb};
    end
    if (pos_q >= LengthFirst && pos_q < HeaderEnd) begin
      length_q = {length_q[HdrW-2:0], lsb};
      if (pos_q == HeaderLast) begin
        header_done_q = 1'b1;
      end
    end
    // The window end is taken one bit wider so that it cannot wrap.
    window_last = {1'b0, offset_q} + {1'b0, length_q};
    if (header_done_q && pos_q > PosW'(offset_q) && pos_q <= PosW'(window_last)) begin
      gather_q = {gather_q[6:0], lsb};
      bits_held_q = bits_held_q + 4'd1;
      if (bits_held_q == 4'd8) begin
        // A key length of zero acts as one; lengths above the limit are clipped.
        klen = (key_len_q == '0) ? 1 : key_len_q;
        if (klen > MaxKeyChars) begin
          klen = MaxKeyChars;
        end
        // A shorter key set while the index sits past its end restarts the key.
        kidx = key_idx_q;
        if (kidx >= klen) begin
          kidx = 0;
        end
        sent_q = sent_q + SentW'(1);
        res.text = gather_q ^ key_q[8*kidx +: 8];
        res.last = (sent_q == length_q[HdrW-1:3]);
        text_expect_q.push_back(res);
        kidx = (kidx + 1 >= klen) ? 0 : kidx + 1;
        key_idx_q = 3'(kidx);
        bits_held_q = '0;
        gather_q = '0;
      end
    end
    // The position saturates instead of wrapping.
    if (pos_q != PosMax) begin
      pos_q = pos_q + PosW'(1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    text_result_t got;
    text_result_t want;
    if (!rst_ni) begin
      key_q = '0;
      key_len_q = KeyLenW'(1);
      pos_q = PosW'(1);
      offset_q = '0;
      length_q = '0;
      header_done_q = 1'b0;
      gather_q = '0;
      bits_held_q = '0;
      key_idx_q = '0;
      sent_q = '0;
      text_expect_q.delete();
    end else begin
      // Output transfer: compare with the oldest predicted byte.
      if (text_valid_i && text_ready_i) begin
        got.text = text_byte_i;
        got.last = last_byte_i;
        if (text_expect_q.size() == 0) begin
          fails++;
          if (fails <= MaxReports) begin
            $display("%0t: unexpected text byte, expected none, got text %02h last %0b",
                     $time, got.text, got.last);
          end
        end else begin
          want = text_expect_q.pop_front();
          checked++;
          if (got.text !== want.text || got.last !== want.last) begin
            fails++;
            if (fails <= MaxReports) begin
              $display({"%0t: text byte %0d mismatch, expected text %02h last %0b, ",
                        "got text %02h last %0b"},
                       $time, checked, want.text, want.last, got.text, got.last);
            end
          end
        end
      end

      // Register writes; unknown indexes leave everything as it was.
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgKeyBytes) begin
          key_q = cfg_data_i;
        end else if (cfg_index_i == CfgKeyLength) begin
          key_len_q = cfg_data_i[KeyLenW-1:0];
        end
      end

      // Input transfer: run the prediction.
      if (cover_valid_i && cover_ready_i) begin
        take_cover_lsb(cover_byte_i[0]);
      end

      // At the end of the run, anything still waiting is a failure.
      if (end_i && !end_seen) begin
        end_seen = 1'b1;
        if (text_expect_q.size() != 0) begin
          $display("%0t: %0d text bytes never arrived, expected text %02h first, got nothing",
                   $time, text_expect_q.size(), text_expect_q[0].text);
          fails += text_expect_q.size();
        end
      end
    end
    fail_count_o <= fails;
    pending_o <= text_expect_q.size();
    checked_o <= checked;
  end

endmodule

// ===== tb/lsb_stego_extractor_test.sv =====
// Testbench top for the LSB steganography extractor: clock, reset, stimulus and verdict.
module lsb_stego_extractor_test;
  import lse_pkg::*;

  localparam int unsigned HalfPeriod = 6;
  localparam int unsigned ResetCycles = 10;
  localparam int unsigned CoverBytes = 2000;
  localparam int unsigned IdleWait = 4;
  localparam int unsigned LongHold = 120;
  localparam int unsigned HoldAt = 600;
  localparam int unsigned DrainLimit = 20000;
  localparam longint unsigned StopTime = 64'd12 * 64'd600000;
  // The window opens three bytes before the header ends, so those bits are lost.
  localparam logic [HdrW-1:0] WindowOffset = HdrW'(259);
  // Register indexes that the block does not decode.
  localparam logic [CfgIdxW-1:0] CfgSpareLow = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgSpareHigh = CfgIdxW'(3);

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cover_valid = 1'b0;
  logic               cover_ready;
  logic [7:0]         cover_byte = '0;
  logic               text_valid;
  logic               text_ready = 1'b0;
  logic [7:0]         text_byte;
  logic               last_byte;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [KeyW-1:0]    cfg_data = '0;
  logic               run_done = 1'b0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned items_sent;
  int unsigned reg_writes;
  bit          calm;
  bit          hold_request;

  always begin
    #HalfPeriod clk = 1'b1;
    #HalfPeriod clk = 1'b0;
  end

  lsb_stego_extractor dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cover_valid_i(cover_valid),
    .cover_ready_o(cover_ready),
    .cover_byte_i (cover_byte),
    .text_valid_o (text_valid),
    .text_ready_i (text_ready),
    .text_byte_o  (text_byte),
    .last_byte_o  (last_byte),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  lsb_stego_extractor_checker text_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cover_valid_i(cover_valid),
    .cover_ready_i(cover_ready),
    .cover_byte_i (cover_byte),
    .text_valid_i (text_valid),
    .text_ready_i (text_ready),
    .text_byte_i  (text_byte),
    .last_byte_i  (last_byte),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .end_i        (run_done),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Idle length for either side: mostly none, sometimes short, rarely long.
  function automatic int unsigned idle_cycles(input bit quiet);
    int unsigned roll;
    if (quiet) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end
    if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Offer one cover byte after a random gap and hold it until the transfer.
  task automatic send_cover(input logic [7:0] value);
    int unsigned gap;
    gap = idle_cycles(calm);
    @(negedge clk);
    if (gap != 0) begin
      cover_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cover_valid = 1'b1;
    cover_byte = value;
    @(posedge clk);
    while (!cover_ready) @(posedge clk);
    items_sent++;
  endtask

  // One register write transfer.
  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [KeyW-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    reg_writes++;
  endtask

  // Drain the block, then load the key setting of the given phase.
  task automatic reconfigure(input int unsigned phase);
    logic [KeyLenW-1:0] klen;
    logic [KeyW-1:0]    key;
    logic [KeyW-1:0]    noise;
    @(negedge clk);
    cover_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    // Bytes outside the window leave no result but may still be in flight.
    repeat (IdleWait) @(posedge clk);
    noise = {$urandom, $urandom};
    // Walk through the edge lengths first: zero, the limit and above it.
    case (phase)
      0: klen = KeyLenW'(1);
      1: klen = KeyLenW'(0);
      2: klen = KeyLenW'(8);
      3: klen = KeyLenW'(15);
      4: klen = KeyLenW'(3);
      5: klen = KeyLenW'(9);
      6: klen = KeyLenW'(2);
      7: klen = KeyLenW'(7);
      default: klen = KeyLenW'($urandom_range(0, 15));
    endcase
    case (phase % 4)
      1: key = '1;
      2: key = '0;
      default: key = {$urandom, $urandom};
    endcase
    write_reg(CfgKeyBytes, key);
    // Upper data bits are noise; only the low nibble counts.
    write_reg(CfgKeyLength, {noise[KeyW-1:KeyLenW], klen});
    if (phase < 2 || $urandom_range(0, 3) == 0) begin
      write_reg((phase % 2 == 0) ? CfgSpareLow : CfgSpareHigh, noise);
    end
  endtask

  // Output side: random back-pressure plus one long hold on request.
  initial begin : text_sink
    int unsigned gap;
    int unsigned burst;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        text_ready = 1'b0;
        repeat (LongHold) @(negedge clk);
        hold_request = 1'b0;
      end
      gap = idle_cycles(calm);
      if (gap != 0) begin
        text_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      text_ready = 1'b1;
      burst = $urandom_range(1, 12);
      repeat (burst - 1) @(negedge clk);
    end
  end

  // Cover stream: extremes first, then the header, then random payload bytes.
  initial begin : stimulus
    logic [HdrW-1:0] payload_bits;
    logic [7:0]      value;
    int unsigned     pos;
    int unsigned     phase;
    int unsigned     next_break;
    int unsigned     guard;
    // A length of 8k+7 keeps the final byte mark reachable despite the lost bits.
    payload_bits = {29'($urandom_range(150, 200)), 3'b111};
    repeat (ResetCycles) @(negedge clk);
    rst_n = 1'b1;
    phase = 0;
    reconfigure(phase);
    next_break = $urandom_range(60, 150);
    for (pos = 1; pos <= CoverBytes; pos++) begin
      if (pos == next_break) begin
        phase++;
        reconfigure(phase);
        calm = ($urandom_range(0, 3) == 0);
        next_break = pos + $urandom_range(30, 150);
      end
      if (pos == HoldAt) begin
        hold_request = 1'b1;
      end
      value = 8'($urandom);
      if (pos <= 6) begin
        case (pos)
          1: value = 8'h00;
          2: value = 8'hFF;
          3: value = 8'h01;
          4: value = 8'hFE;
          5: value = 8'h80;
          default: value = 8'h7F;
        endcase
      end else if (pos >= OffsetFirst && pos < LengthFirst) begin
        value[0] = WindowOffset[LengthFirst - 1 - pos];
      end else if (pos >= LengthFirst && pos < HeaderEnd) begin
        value[0] = payload_bits[HeaderLast - pos];
      end
      send_cover(value);
    end
    @(negedge clk);
    cover_valid = 1'b0;

    // Let every expected byte come out, then watch a little longer.
    guard = 0;
    while (pending != 0 && guard < DrainLimit) begin
      @(posedge clk);
      guard++;
    end
    repeat (IdleWait * 4) @(posedge clk);
    @(negedge clk);
    run_done = 1'b1;
    @(posedge clk);
    @(negedge clk);

    $display("Run summary: %0d cover bytes over %0d key settings, %0d register writes.",
             items_sent, phase + 1, reg_writes);
    $display("Payload window after byte %0d, %0d bits long; %0d text bytes compared, %0d failures.",
             WindowOffset, payload_bits, checked, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin : watchdog
    #(StopTime);
    $display("Timeout: the run did not complete in time.");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lse_pkg.sv
rtl/core/lse_frame.sv
rtl/core/lsb_stego_extractor.sv
tb/lsb_stego_extractor_checker.sv
tb/lsb_stego_extractor_test.sv
